[rtl/ial_pkg.sv]
// ----------------------------------------------------------------------------
// ial_pkg
// Shared types and constants for the indexed array list.
// ----------------------------------------------------------------------------
package ial_pkg;

   localparam int DEPTH  = 16;
   localparam int POS_W  = 5;
   localparam int VAL_W  = 32;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int LIM_W  = 5;
   localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_LOCATE = 2'd2,
      OP_NONE   = 2'd3
   } ial_op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } ial_status_type;

   typedef struct packed {
      ial_op_type               req_type;
      logic [POS_W-1:0]         position;
      logic signed [VAL_W-1:0]  item_value;
   } ial_req_type;

   typedef struct packed {
      ial_status_type           status;
      logic signed [VAL_W-1:0]  removed_value;
      logic [IDX_W-1:0]         found_position;
      logic [CNT_W-1:0]         entry_count;
   } ial_rsp_type;

   typedef struct packed {
      logic load_new;
      logic take_left;
      logic take_right;
   } ial_cell_ctl_type;

endpackage

[rtl/ial_cell.sv]
// ----------------------------------------------------------------------------
// ial_cell
// One list position: holds an entry, shifts from either neighbor, compares.
// ----------------------------------------------------------------------------
module ial_cell (
   input  logic                            clock,
   input  ial_pkg::ial_cell_ctl_type       ctl,
   input  logic signed [ial_pkg::VAL_W-1:0] new_value,
   input  logic signed [ial_pkg::VAL_W-1:0] left_value,
   input  logic signed [ial_pkg::VAL_W-1:0] right_value,
   input  logic signed [ial_pkg::VAL_W-1:0] key,
   output logic signed [ial_pkg::VAL_W-1:0] entry,
   output logic                            match
);

   logic signed [ial_pkg::VAL_W-1:0] entry_ff;
   logic signed [ial_pkg::VAL_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.load_new) begin
         entry_in = new_value;
      end else if (ctl.take_left) begin
         entry_in = left_value;
      end else if (ctl.take_right) begin
         entry_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign match = (entry_ff == key);

endmodule

[rtl/indexed_array_list.sv]
// A result word appears in the cycle after its request word is taken.
// Throughput: one request per cycle unless the result stalls; every cell
// shifts or compares at once; a stalled result register holds input.
// Reset: synchronous; clears the count, the result valid and sets the
// capacity limit to the full depth. Entry contents are not cleared.
// ----------------------------------------------------------------------------
// indexed_array_list
// Packed ordered list with insert, delete and locate over a row of cells.
// ----------------------------------------------------------------------------
module indexed_array_list (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  ial_pkg::ial_req_type         req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output ial_pkg::ial_rsp_type         rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [ial_pkg::LIM_W-1:0]    csr_data
);

   logic [ial_pkg::LIM_W-1:0]           limit_ff;
   logic [ial_pkg::CNT_W-1:0]           count_ff;
   logic [ial_pkg::CNT_W-1:0]           count_in;
   logic                                rsp_valid_ff;
   ial_pkg::ial_rsp_type                rsp_data_ff;
   ial_pkg::ial_rsp_type                rsp_data_in;

   logic                                accept;
   logic [ial_pkg::CMP_W-1:0]           pos_x;
   logic [ial_pkg::CMP_W-1:0]           cnt_x;
   logic [ial_pkg::CMP_W-1:0]           lim_x;
   logic                                ins_ok;
   logic                                del_ok;

   ial_pkg::ial_cell_ctl_type           ctl   [ial_pkg::DEPTH];
   logic signed [ial_pkg::VAL_W-1:0]    entry [ial_pkg::DEPTH];
   logic [ial_pkg::DEPTH-1:0]           match;
   logic [ial_pkg::DEPTH-1:0]           hit;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign pos_x = ial_pkg::CMP_W'(req_data.position);
   assign cnt_x = ial_pkg::CMP_W'(count_ff);
   assign lim_x = (ial_pkg::CMP_W'(limit_ff) < ial_pkg::CMP_W'(ial_pkg::DEPTH)) ?
                  ial_pkg::CMP_W'(limit_ff) : ial_pkg::CMP_W'(ial_pkg::DEPTH);

   assign ins_ok = (req_data.req_type == ial_pkg::OP_INSERT) &&
                   (pos_x <= cnt_x) && (cnt_x < lim_x);
   assign del_ok = (req_data.req_type == ial_pkg::OP_DELETE) && (pos_x < cnt_x);

   for (genvar i = 0; i < ial_pkg::DEPTH; i++) begin : g_cell
      logic signed [ial_pkg::VAL_W-1:0] left_v;
      logic signed [ial_pkg::VAL_W-1:0] right_v;

      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_mid_l
         assign left_v = entry[i-1];
      end
      if (i == ial_pkg::DEPTH - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_mid_r
         assign right_v = entry[i+1];
      end

      assign ctl[i].load_new   = accept && ins_ok && (pos_x == ial_pkg::CMP_W'(i));
      assign ctl[i].take_left  = accept && ins_ok && (pos_x <  ial_pkg::CMP_W'(i));
      assign ctl[i].take_right = accept && del_ok && (pos_x <= ial_pkg::CMP_W'(i));
      assign hit[i] = match[i] && (ial_pkg::CMP_W'(i) < cnt_x);

      ial_cell u_cell (
         .clock       (clock),
         .ctl         (ctl[i]),
         .new_value   (req_data.item_value),
         .left_value  (left_v),
         .right_value (right_v),
         .key         (req_data.item_value),
         .entry       (entry[i]),
         .match       (match[i])
      );
   end

   always_comb begin
      rsp_data_in               = '0;
      rsp_data_in.status        = ial_pkg::ST_OK;
      count_in                  = count_ff;
      case (req_data.req_type)
         ial_pkg::OP_INSERT: begin
            if (pos_x > cnt_x) begin
               rsp_data_in.status = ial_pkg::ST_RANGE;
            end else if (!ins_ok) begin
               rsp_data_in.status = ial_pkg::ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ial_pkg::OP_DELETE: begin
            if (!del_ok) begin
               rsp_data_in.status = ial_pkg::ST_RANGE;
            end else begin
               rsp_data_in.removed_value = entry[req_data.position[ial_pkg::IDX_W-1:0]];
               count_in = count_ff - 1'b1;
            end
         end
         ial_pkg::OP_LOCATE: begin
            rsp_data_in.status = ial_pkg::ST_NOTFOUND;
            for (int i = 0; i < ial_pkg::DEPTH; i++) begin
               if (hit[i]) begin
                  rsp_data_in.status         = ial_pkg::ST_OK;
                  rsp_data_in.found_position = ial_pkg::IDX_W'(i);
               end
            end
         end
         default: begin
            rsp_data_in.status = ial_pkg::ST_OK;
         end
      endcase
      rsp_data_in.entry_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= ial_pkg::LIM_W'(ial_pkg::DEPTH);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/ial_checker.sv]
// ----------------------------------------------------------------------------
// ial_checker
// Port-level checks for the indexed array list.
// ----------------------------------------------------------------------------
module ial_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  ial_pkg::ial_rsp_type         rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_req_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request word gave no result word");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= ial_pkg::CNT_W'(ial_pkg::DEPTH))
      else $error("entry count beyond depth");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ial_pkg::ST_OK
      |-> rsp_data.removed_value == '0 && rsp_data.found_position == '0)
      else $error("failed request carries nonzero data");

endmodule

bind indexed_array_list ial_checker u_ial_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
